@@ sv/ptpd_pkg.sv @@
// Shared types and constants for the pan/tilt PD tracker.
// No dependencies; imported by every other file of the block.
`timescale 1ns / 1ps
`default_nettype none

package ptpd_pkg;

   localparam int ValueWidth = 16;
   localparam int GainWidth  = 16;
   localparam int OpWidth    = 3;
   localparam int CsrAddrWidth = 3;
   localparam int FracShift  = 12;   // Q4.12 gains

   // op codes
   localparam logic [OpWidth-1:0] OP_TRACK    = 3'd0;
   localparam logic [OpWidth-1:0] OP_ABSOLUTE = 3'd1;
   localparam logic [OpWidth-1:0] OP_OFFSET   = 3'd2;
   localparam logic [OpWidth-1:0] OP_HOME     = 3'd3;
   localparam logic [OpWidth-1:0] OP_CLEAR    = 3'd4;

   // register indexes
   localparam logic [CsrAddrWidth-1:0] REG_PAN_UPPER  = 3'd0;
   localparam logic [CsrAddrWidth-1:0] REG_PAN_LOWER  = 3'd1;
   localparam logic [CsrAddrWidth-1:0] REG_TILT_UPPER = 3'd2;
   localparam logic [CsrAddrWidth-1:0] REG_TILT_LOWER = 3'd3;
   localparam logic [CsrAddrWidth-1:0] REG_PAN_KP     = 3'd4;
   localparam logic [CsrAddrWidth-1:0] REG_PAN_KD     = 3'd5;
   localparam logic [CsrAddrWidth-1:0] REG_TILT_KP    = 3'd6;
   localparam logic [CsrAddrWidth-1:0] REG_TILT_KD    = 3'd7;

   // reset values: +/-45.0 degrees in Q8.8, gains about 0.1 in Q4.12
   localparam logic signed [ValueWidth-1:0] UPPER_RESET = 16'sd11520;
   localparam logic signed [ValueWidth-1:0] LOWER_RESET = -16'sd11520;
   localparam logic [GainWidth-1:0]         GAIN_RESET  = 16'd410;

   localparam logic signed [ValueWidth-1:0] PAN_HOME  = 16'sd0;
   localparam logic signed [ValueWidth-1:0] TILT_HOME = 16'sd0;

   // pipeline control shared by both lanes
   typedef struct packed {
      logic accept;    // beat taken into the product stage
      logic advance;   // product stage moves into the position registers
   } ctrl_type;

   // per-axis settings
   typedef struct packed {
      logic signed [ValueWidth-1:0] upper;
      logic signed [ValueWidth-1:0] lower;
      logic [GainWidth-1:0]         kp;
      logic [GainWidth-1:0]         kd;
      logic signed [ValueWidth-1:0] home;
   } axis_cfg_type;

endpackage : ptpd_pkg

`default_nettype wire

@@ sv/pan_tilt_pd_tracker_core.sv @@
// Top level of the pan/tilt PD tracker: settings registers, two axis lanes, merge stage.
// Depends on ptpd_pkg, ptpd_axis_lane and ptpd_merge.
`timescale 1ns / 1ps
`default_nettype none

// Two-axis position controller. Each request beat carries an op (track, move absolute,
// move offset, move home, clear tracking) and a signed Q8.8 value per axis; each one gives
// exactly one response beat with both clamped positions in Q8.8. Track adds
// kp*error + kd*(error - last error), with unsigned Q4.12 gains, rounded half up.
// An accepted request is registered in the product registers, then in the position
// registers, which drive the response beat: the gain multipliers sit in front of the
// product registers; the sum, the position add and the clamp close the position
// feedback loop behind them. Both axes run in parallel lanes, so one beat is accepted
// every cycle while the response side keeps up. The user must write settings registers
// through the csr port only while no beat is in flight; the block does not enforce it.

module pan_tilt_pd_tracker_core (
   input  wire                                    clock,
   input  wire                                    reset,
   input  wire                                    req_valid,
   output logic                                   req_stall,
   input  wire [ptpd_pkg::OpWidth-1:0]            req_op,
   input  wire signed [ptpd_pkg::ValueWidth-1:0]  req_pan_value,
   input  wire signed [ptpd_pkg::ValueWidth-1:0]  req_tilt_value,
   output logic                                   rsp_valid,
   input  wire                                    rsp_stall,
   output logic signed [ptpd_pkg::ValueWidth-1:0] rsp_pan_angle,
   output logic signed [ptpd_pkg::ValueWidth-1:0] rsp_tilt_angle,
   input  wire                                    csr_wr_en,
   input  wire [ptpd_pkg::CsrAddrWidth-1:0]       csr_addr,
   input  wire [ptpd_pkg::ValueWidth-1:0]         csr_wr_data
);
   import ptpd_pkg::*;

   logic signed [ValueWidth-1:0] pan_upper_ff, pan_lower_ff, tilt_upper_ff, tilt_lower_ff;
   logic [GainWidth-1:0]         pan_kp_ff, pan_kd_ff, tilt_kp_ff, tilt_kd_ff;

   ctrl_type                     ctrl;
   axis_cfg_type                 pan_cfg, tilt_cfg;
   logic signed [ValueWidth-1:0] pan_position, tilt_position;

   always_ff @(posedge clock) begin
      if (reset) begin
         pan_upper_ff  <= UPPER_RESET;
         pan_lower_ff  <= LOWER_RESET;
         tilt_upper_ff <= UPPER_RESET;
         tilt_lower_ff <= LOWER_RESET;
         pan_kp_ff     <= GAIN_RESET;
         pan_kd_ff     <= GAIN_RESET;
         tilt_kp_ff    <= GAIN_RESET;
         tilt_kd_ff    <= GAIN_RESET;
      end else if (csr_wr_en) begin
         case (csr_addr)
            REG_PAN_UPPER:  pan_upper_ff  <= $signed(csr_wr_data);
            REG_PAN_LOWER:  pan_lower_ff  <= $signed(csr_wr_data);
            REG_TILT_UPPER: tilt_upper_ff <= $signed(csr_wr_data);
            REG_TILT_LOWER: tilt_lower_ff <= $signed(csr_wr_data);
            REG_PAN_KP:     pan_kp_ff     <= csr_wr_data;
            REG_PAN_KD:     pan_kd_ff     <= csr_wr_data;
            REG_TILT_KP:    tilt_kp_ff    <= csr_wr_data;
            REG_TILT_KD:    tilt_kd_ff    <= csr_wr_data;
            default:        pan_upper_ff  <= pan_upper_ff;
         endcase
      end
   end

   always_comb begin
      pan_cfg.upper  = pan_upper_ff;
      pan_cfg.lower  = pan_lower_ff;
      pan_cfg.kp     = pan_kp_ff;
      pan_cfg.kd     = pan_kd_ff;
      pan_cfg.home   = PAN_HOME;
      tilt_cfg.upper = tilt_upper_ff;
      tilt_cfg.lower = tilt_lower_ff;
      tilt_cfg.kp    = tilt_kp_ff;
      tilt_cfg.kd    = tilt_kd_ff;
      tilt_cfg.home  = TILT_HOME;
   end

   ptpd_axis_lane u_pan_lane (
      .clock    (clock),
      .reset    (reset),
      .ctrl     (ctrl),
      .cfg      (pan_cfg),
      .op       (req_op),
      .value    (req_pan_value),
      .position (pan_position)
   );

   ptpd_axis_lane u_tilt_lane (
      .clock    (clock),
      .reset    (reset),
      .ctrl     (ctrl),
      .cfg      (tilt_cfg),
      .op       (req_op),
      .value    (req_tilt_value),
      .position (tilt_position)
   );

   ptpd_merge u_merge (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .pan_position   (pan_position),
      .tilt_position  (tilt_position),
      .rsp_pan_angle  (rsp_pan_angle),
      .rsp_tilt_angle (rsp_tilt_angle),
      .ctrl           (ctrl)
   );

   // a finished beat always shows up on the response side
   a_advance_gives_rsp : assert property (@(posedge clock) disable iff (reset)
      ctrl.advance |=> rsp_valid)
      else $error("advance did not produce a response beat");

   // never overwrite a response that is being held
   a_no_overwrite : assert property (@(posedge clock) disable iff (reset)
      ctrl.advance |-> !(rsp_valid && rsp_stall))
      else $error("position updated under a stalled response");

   // positions move only when the product stage advances
   a_pos_hold : assert property (@(posedge clock) disable iff (reset)
      (!reset && !ctrl.advance) |=> ($stable(rsp_pan_angle) && $stable(rsp_tilt_angle)))
      else $error("position changed without an advance");

endmodule : pan_tilt_pd_tracker_core

`default_nettype wire

@@ sv/ptpd_axis_lane.sv @@
// One axis of the tracker: product stage, last error, position update and clamp.
// Depends on ptpd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ptpd_axis_lane (
   input  wire                              clock,
   input  wire                              reset,
   input  ptpd_pkg::ctrl_type               ctrl,
   input  ptpd_pkg::axis_cfg_type           cfg,
   input  wire [ptpd_pkg::OpWidth-1:0]      op,
   input  wire signed [ptpd_pkg::ValueWidth-1:0] value,
   output logic signed [ptpd_pkg::ValueWidth-1:0] position
);
   import ptpd_pkg::*;

   localparam int ProdPWidth = ValueWidth + GainWidth + 1;   // 16s x 17s
   localparam int ProdDWidth = ValueWidth + GainWidth + 2;   // 17s x 17s
   localparam int SumWidth   = ProdDWidth + 1;
   localparam int StepWidth  = SumWidth - FracShift;
   localparam int NextWidth  = StepWidth + 1;

   logic [OpWidth-1:0]              op_ff;
   logic signed [ValueWidth-1:0]    value_ff;
   logic signed [ProdPWidth-1:0]    prod_p_ff, prod_p_in;
   logic signed [ProdDWidth-1:0]    prod_d_ff, prod_d_in;
   logic signed [ValueWidth-1:0]    last_err_ff, last_err_in;
   logic signed [ValueWidth-1:0]    pos_ff, pos_in;

   logic signed [ValueWidth:0]      change;
   logic signed [SumWidth-1:0]      sum;
   logic signed [StepWidth-1:0]     step;
   logic signed [NextWidth-1:0]     next_pos;
   logic signed [NextWidth-1:0]     upper_x, lower_x;

   // product stage
   always_comb begin
      change    = $signed({value[ValueWidth-1], value}) -
                  $signed({last_err_ff[ValueWidth-1], last_err_ff});
      prod_p_in = value * $signed({1'b0, cfg.kp});
      prod_d_in = change * $signed({1'b0, cfg.kd});
      last_err_in = last_err_ff;
      case (op)
         OP_TRACK: last_err_in = value;
         OP_CLEAR: last_err_in = '0;
         default:  last_err_in = last_err_ff;
      endcase
   end

   // position stage: round half up to Q8.8, apply op, clamp
   always_comb begin
      sum  = SumWidth'(prod_p_ff) + SumWidth'(prod_d_ff) +
             $signed(SumWidth'(1 << (FracShift - 1)));
      step = sum[SumWidth-1:FracShift];
      upper_x = NextWidth'(cfg.upper);
      lower_x = NextWidth'(cfg.lower);
      case (op_ff)
         OP_TRACK:    next_pos = NextWidth'(pos_ff) + NextWidth'(step);
         OP_ABSOLUTE: next_pos = NextWidth'(value_ff);
         OP_OFFSET:   next_pos = NextWidth'(pos_ff) + NextWidth'(value_ff);
         OP_HOME:     next_pos = NextWidth'(cfg.home);
         default:     next_pos = NextWidth'(pos_ff);
      endcase
      // upper limit is tested first, so it wins when a value is above it and below the lower limit
      if (next_pos > upper_x) begin
         pos_in = cfg.upper;
      end else if (next_pos < lower_x) begin
         pos_in = cfg.lower;
      end else begin
         pos_in = next_pos[ValueWidth-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_err_ff <= '0;
         pos_ff      <= cfg.home;
      end else begin
         if (ctrl.accept) begin
            last_err_ff <= last_err_in;
         end
         if (ctrl.advance) begin
            pos_ff <= pos_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.accept) begin
         op_ff     <= op;
         value_ff  <= value;
         prod_p_ff <= prod_p_in;
         prod_d_ff <= prod_d_in;
      end
   end

   assign position = pos_ff;

endmodule : ptpd_axis_lane

`default_nettype wire

@@ sv/ptpd_merge.sv @@
// Merge stage: pipeline occupancy, handshakes, and the joined pan/tilt beat.
// Depends on ptpd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ptpd_merge (
   input  wire                                    clock,
   input  wire                                    reset,
   input  wire                                    req_valid,
   output logic                                   req_stall,
   output logic                                   rsp_valid,
   input  wire                                    rsp_stall,
   input  wire signed [ptpd_pkg::ValueWidth-1:0]  pan_position,
   input  wire signed [ptpd_pkg::ValueWidth-1:0]  tilt_position,
   output logic signed [ptpd_pkg::ValueWidth-1:0] rsp_pan_angle,
   output logic signed [ptpd_pkg::ValueWidth-1:0] rsp_tilt_angle,
   output ptpd_pkg::ctrl_type                     ctrl
);
   import ptpd_pkg::*;

   logic s1_valid_ff, s1_valid_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic out_free;

   always_comb begin
      out_free     = !rsp_valid_ff || !rsp_stall;
      ctrl.advance = s1_valid_ff && out_free;
      req_stall    = s1_valid_ff && !out_free;
      ctrl.accept  = req_valid && !req_stall;
      s1_valid_in  = ctrl.accept || (s1_valid_ff && !ctrl.advance);
      rsp_valid_in = ctrl.advance || (rsp_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // lane position registers double as the output payload; they only move on advance
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_pan_angle  = pan_position;
   assign rsp_tilt_angle = tilt_position;

endmodule : ptpd_merge

`default_nettype wire

@@ tb/sv/tb_pan_tilt_pd_tracker_core.sv @@
// Self-checking testbench for pan_tilt_pd_tracker_core: directed table, then random phases.
// Depends on ptpd_pkg and the core RTL; predicts response beats in SystemVerilog, bar literal rows.
`timescale 1ns / 1ps

module tb_pan_tilt_pd_tracker_core;
   import ptpd_pkg::*;

   localparam int RUN_LIMIT     = 200000;
   localparam int PIPE_DEPTH    = 4;
   localparam int SETTLE_CYCLES = 8;
   localparam int PHASES        = 12;
   localparam int PHASE_BEATS   = 145;
   localparam int PRESSURE_HOLD = 80;

   localparam logic [OpWidth-1:0] OP_UNUSED_FIRST = 3'd5;
   localparam logic [OpWidth-1:0] OP_UNUSED_LAST  = 3'd7;

   localparam logic signed [ValueWidth-1:0] VMAX = 16'sh7FFF;
   localparam logic signed [ValueWidth-1:0] VMIN = 16'sh8000;
   localparam logic signed [ValueWidth-1:0] ZERO = 16'sh0000;
   localparam logic [GainWidth-1:0]         GAIN_MAX = 16'hFFFF;

   typedef struct packed {
      logic signed [ValueWidth-1:0] pan;
      logic signed [ValueWidth-1:0] tilt;
   } angles_type;

   typedef enum logic {ROW_BEAT, ROW_CSR} row_kind_type;

   // code is the op for a beat row, the register index for a register row
   typedef struct packed {
      row_kind_type                 kind;
      logic [OpWidth-1:0]           code;
      logic signed [ValueWidth-1:0] pan;
      logic signed [ValueWidth-1:0] tilt;
      logic                         literal;
      logic signed [ValueWidth-1:0] exp_pan;
      logic signed [ValueWidth-1:0] exp_tilt;
   } row_type;

   localparam row_type DIRECTED [27] = '{
      '{ROW_BEAT, OP_HOME,     ZERO, ZERO, 1'b1, ZERO, ZERO},
      '{ROW_BEAT, OP_ABSOLUTE, VMAX, VMIN, 1'b1, UPPER_RESET, LOWER_RESET},
      '{ROW_BEAT, OP_ABSOLUTE, 16'sd100, -16'sd200, 1'b1, 16'sd100, -16'sd200},
      '{ROW_BEAT, OP_OFFSET,   VMAX, VMAX, 1'b1, UPPER_RESET, UPPER_RESET},
      '{ROW_BEAT, OP_OFFSET,   VMIN, VMIN, 1'b1, LOWER_RESET, LOWER_RESET},
      '{ROW_BEAT, OP_TRACK,    VMAX, VMIN, 1'b0, ZERO, ZERO},
      '{ROW_BEAT, OP_TRACK,    VMIN, VMAX, 1'b0, ZERO, ZERO},
      '{ROW_BEAT, OP_CLEAR,    16'sd1234, -16'sd1, 1'b0, ZERO, ZERO},
      '{ROW_BEAT, OP_TRACK,    16'sd256, -16'sd256, 1'b0, ZERO, ZERO},
      '{ROW_BEAT, OP_UNUSED_FIRST, -16'sd1, ZERO, 1'b0, ZERO, ZERO},
      '{ROW_BEAT, OP_UNUSED_LAST,  ZERO, -16'sd1, 1'b0, ZERO, ZERO},
      // pan kp of one half exposes the round-half-up step
      '{ROW_CSR,  REG_PAN_KP,  16'sh0800, ZERO, 1'b0, ZERO, ZERO},
      '{ROW_CSR,  REG_PAN_KD,  ZERO, ZERO, 1'b0, ZERO, ZERO},
      '{ROW_CSR,  REG_TILT_KP, GAIN_MAX, ZERO, 1'b0, ZERO, ZERO},
      '{ROW_CSR,  REG_TILT_KD, GAIN_MAX, ZERO, 1'b0, ZERO, ZERO},
      '{ROW_BEAT, OP_ABSOLUTE, ZERO, ZERO, 1'b1, ZERO, ZERO},
      '{ROW_BEAT, OP_CLEAR,    ZERO, ZERO, 1'b1, ZERO, ZERO},
      '{ROW_BEAT, OP_TRACK,    16'sd1, -16'sd1, 1'b0, ZERO, ZERO},
      '{ROW_BEAT, OP_TRACK,    -16'sd1, 16'sd1, 1'b0, ZERO, ZERO},
      // inverted pan limits: upper wins where both are crossed; tilt opened to the full range
      '{ROW_CSR,  REG_PAN_UPPER,  -16'sd100, ZERO, 1'b0, ZERO, ZERO},
      '{ROW_CSR,  REG_PAN_LOWER,  16'sd100, ZERO, 1'b0, ZERO, ZERO},
      '{ROW_CSR,  REG_TILT_UPPER, VMAX, ZERO, 1'b0, ZERO, ZERO},
      '{ROW_CSR,  REG_TILT_LOWER, VMIN, ZERO, 1'b0, ZERO, ZERO},
      '{ROW_BEAT, OP_ABSOLUTE, ZERO, VMIN, 1'b1, -16'sd100, VMIN},
      '{ROW_BEAT, OP_ABSOLUTE, VMIN, VMAX, 1'b1, 16'sd100, VMAX},
      '{ROW_BEAT, OP_OFFSET,   VMAX, VMAX, 1'b1, -16'sd100, VMAX},
      '{ROW_BEAT, OP_HOME,     VMIN, VMIN, 1'b1, -16'sd100, ZERO}
   };

   logic                         clock = 1'b0;
   logic                         reset = 1'b1;
   logic                         req_valid = 1'b0;
   logic                         req_stall;
   logic [OpWidth-1:0]           req_op = '0;
   logic signed [ValueWidth-1:0] req_pan_value = '0;
   logic signed [ValueWidth-1:0] req_tilt_value = '0;
   logic                         rsp_valid;
   logic                         rsp_stall = 1'b0;
   logic signed [ValueWidth-1:0] rsp_pan_angle;
   logic signed [ValueWidth-1:0] rsp_tilt_angle;
   logic                         csr_wr_en = 1'b0;
   logic [CsrAddrWidth-1:0]      csr_addr = '0;
   logic [ValueWidth-1:0]        csr_wr_data = '0;

   // predictor state and settings
   axis_cfg_type                 pan_cfg;
   axis_cfg_type                 tilt_cfg;
   logic signed [ValueWidth-1:0] pan_pos;
   logic signed [ValueWidth-1:0] tilt_pos;
   logic signed [ValueWidth-1:0] pan_err_prev;
   logic signed [ValueWidth-1:0] tilt_err_prev;

   angles_type pending_angles[$];
   int         bad_beats = 0;
   int         cycles = 0;
   bit         eager_phase = 1'b0;

   pan_tilt_pd_tracker_core i_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_op         (req_op),
      .req_pan_value  (req_pan_value),
      .req_tilt_value (req_tilt_value),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_pan_angle  (rsp_pan_angle),
      .rsp_tilt_angle (rsp_tilt_angle),
      .csr_wr_en      (csr_wr_en),
      .csr_addr       (csr_addr),
      .csr_wr_data    (csr_wr_data)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == RUN_LIMIT) begin
         $display("tb_pan_tilt_pd_tracker_core failed");
         $finish;
      end
   end

   // kp*error + kd*(error - last error) in Q.20, rounded half up to Q8.8
   function automatic longint pd_increment(input logic signed [ValueWidth-1:0] err,
                                           input logic signed [ValueWidth-1:0] last,
                                           input axis_cfg_type cfg);
      longint e, l, kp, kd;
      e  = err;
      l  = last;
      kp = cfg.kp;
      kd = cfg.kd;
      return (e * kp + (e - l) * kd + 2048) >>> FracShift;
   endfunction

   // upper limit tested first, so it wins when a value is above it and below the lower limit
   function automatic logic signed [ValueWidth-1:0] clamp_axis(input longint pos,
                                                               input axis_cfg_type cfg);
      longint hi, lo;
      hi = $signed(cfg.upper);
      lo = $signed(cfg.lower);
      if (pos > hi) return cfg.upper;
      if (pos < lo) return cfg.lower;
      return 16'(pos);
   endfunction

   function automatic angles_type advance_positions(input logic [OpWidth-1:0] op,
                                                    input logic signed [ValueWidth-1:0] pan_in,
                                                    input logic signed [ValueWidth-1:0] tilt_in);
      longint pan_next, tilt_next;
      angles_type result;
      pan_next  = pan_pos;
      tilt_next = tilt_pos;
      case (op)
         OP_TRACK: begin
            pan_next      = pan_next + pd_increment(pan_in, pan_err_prev, pan_cfg);
            tilt_next     = tilt_next + pd_increment(tilt_in, tilt_err_prev, tilt_cfg);
            pan_err_prev  = pan_in;
            tilt_err_prev = tilt_in;
         end
         OP_ABSOLUTE: begin
            pan_next  = pan_in;
            tilt_next = tilt_in;
         end
         OP_OFFSET: begin
            pan_next  = pan_next + longint'(pan_in);
            tilt_next = tilt_next + longint'(tilt_in);
         end
         OP_HOME: begin
            pan_next  = $signed(pan_cfg.home);
            tilt_next = $signed(tilt_cfg.home);
         end
         OP_CLEAR: begin
            pan_err_prev  = '0;
            tilt_err_prev = '0;
         end
         default: ;
      endcase
      pan_pos     = clamp_axis(pan_next, pan_cfg);
      tilt_pos    = clamp_axis(tilt_next, tilt_cfg);
      result.pan  = pan_pos;
      result.tilt = tilt_pos;
      return result;
   endfunction

   task automatic send_beat(input logic [OpWidth-1:0] op,
                            input logic signed [ValueWidth-1:0] pan_in,
                            input logic signed [ValueWidth-1:0] tilt_in,
                            input logic literal, input angles_type typed);
      int gap;
      angles_type predicted;
      gap = eager_phase ? 0 : $urandom_range(0, 3);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_op         <= op;
      req_pan_value  <= pan_in;
      req_tilt_value <= tilt_in;
      do @(posedge clock); while (req_stall !== 1'b0);
      predicted = advance_positions(op, pan_in, tilt_in);
      pending_angles.push_back(literal ? typed : predicted);
   endtask

   // drop valid and let every beat in flight come out before touching settings
   task automatic drain_pipeline();
      req_valid <= 1'b0;
      while (pending_angles.size() != 0) @(posedge clock);
      repeat (PIPE_DEPTH) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CsrAddrWidth-1:0] index,
                            input logic [ValueWidth-1:0] data);
      csr_wr_en   <= 1'b1;
      csr_addr    <= index;
      csr_wr_data <= data;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      @(posedge clock);
      case (index)
         REG_PAN_UPPER:  pan_cfg.upper  = data;
         REG_PAN_LOWER:  pan_cfg.lower  = data;
         REG_TILT_UPPER: tilt_cfg.upper = data;
         REG_TILT_LOWER: tilt_cfg.lower = data;
         REG_PAN_KP:     pan_cfg.kp     = data;
         REG_PAN_KD:     pan_cfg.kd     = data;
         REG_TILT_KP:    tilt_cfg.kp    = data;
         REG_TILT_KD:    tilt_cfg.kd    = data;
         default: ;
      endcase
   endtask

   function automatic logic [GainWidth-1:0] draw_gain();
      int pick;
      pick = $urandom_range(0, 7);
      if (pick == 0) return '0;
      if (pick == 1) return GAIN_MAX;
      if (pick < 5) return 16'($urandom_range(0, 1023));
      return 16'($urandom);
   endfunction

   function automatic axis_cfg_type draw_axis(input int phase,
                                              input logic signed [ValueWidth-1:0] home);
      axis_cfg_type cfg;
      logic signed [ValueWidth-1:0] a, b;
      int pick;
      cfg.home = home;
      a = 16'($urandom);
      b = 16'($urandom);
      pick = $urandom_range(0, 9);
      if (phase == 0) begin
         cfg.upper = UPPER_RESET;
         cfg.lower = LOWER_RESET;
         cfg.kp    = GAIN_RESET;
         cfg.kd    = GAIN_RESET;
         return cfg;
      end
      if (phase == 1 || pick == 0) begin
         cfg.upper = VMAX;
         cfg.lower = VMIN;
      end else if (pick == 1) begin
         cfg.upper = (a < b) ? a : b;
         cfg.lower = (a < b) ? b : a;
      end else if (pick == 2) begin
         cfg.upper = a;
         cfg.lower = a;
      end else if (pick < 6) begin
         cfg.upper = 16'($urandom_range(0, 16384));
         cfg.lower = -cfg.upper;
      end else begin
         cfg.upper = (a < b) ? b : a;
         cfg.lower = (a < b) ? a : b;
      end
      cfg.kp = (phase == 1) ? GAIN_MAX : draw_gain();
      cfg.kd = (phase == 1) ? GAIN_MAX : draw_gain();
      return cfg;
   endfunction

   task automatic choose_settings(input int phase);
      axis_cfg_type pan_new, tilt_new;
      pan_new  = draw_axis(phase, PAN_HOME);
      tilt_new = draw_axis(phase, TILT_HOME);
      write_reg(REG_PAN_UPPER, pan_new.upper);
      write_reg(REG_PAN_LOWER, pan_new.lower);
      write_reg(REG_TILT_UPPER, tilt_new.upper);
      write_reg(REG_TILT_LOWER, tilt_new.lower);
      write_reg(REG_PAN_KP, pan_new.kp);
      write_reg(REG_PAN_KD, pan_new.kd);
      write_reg(REG_TILT_KP, tilt_new.kp);
      write_reg(REG_TILT_KD, tilt_new.kd);
   endtask

   // mostly small tracking errors as a camera loop would see, full range now and then
   function automatic logic signed [ValueWidth-1:0] draw_value(input bit wide);
      int v;
      if (wide) return 16'($urandom);
      v = $urandom_range(0, 4095) - 2048;
      return 16'(v);
   endfunction

   initial begin : response_side
      int hold;
      int taken;
      angles_type want;
      taken = 0;
      do @(posedge clock); while (reset !== 1'b0);
      forever begin
         if (taken == 500 || taken == 1300) hold = PRESSURE_HOLD;
         else hold = eager_phase ? 0 : $urandom_range(0, 3);
         if (hold > 0) begin
            rsp_stall <= 1'b1;
            repeat (hold) @(posedge clock);
            rsp_stall <= 1'b0;
         end
         do @(posedge clock); while (rsp_valid !== 1'b1);
         taken++;
         if (pending_angles.size() == 0) begin
            $display("%0t: unexpected response beat, pan %0d tilt %0d", $time,
                     rsp_pan_angle, rsp_tilt_angle);
            bad_beats++;
         end else begin
            want = pending_angles.pop_front();
            if (rsp_pan_angle !== want.pan) begin
               $display("%0t: pan_angle expected %0d, got %0d", $time,
                        $signed(want.pan), rsp_pan_angle);
               bad_beats++;
            end
            if (rsp_tilt_angle !== want.tilt) begin
               $display("%0t: tilt_angle expected %0d, got %0d", $time,
                        $signed(want.tilt), rsp_tilt_angle);
               bad_beats++;
            end
         end
      end
   end

   initial begin : request_side
      bit after_beat;
      int pick;
      logic [OpWidth-1:0] op;
      logic signed [ValueWidth-1:0] pan_in, tilt_in;
      pan_cfg       = '{upper: UPPER_RESET, lower: LOWER_RESET, kp: GAIN_RESET,
                        kd: GAIN_RESET, home: PAN_HOME};
      tilt_cfg      = '{upper: UPPER_RESET, lower: LOWER_RESET, kp: GAIN_RESET,
                        kd: GAIN_RESET, home: TILT_HOME};
      pan_pos       = PAN_HOME;
      tilt_pos      = TILT_HOME;
      pan_err_prev  = '0;
      tilt_err_prev = '0;
      after_beat    = 1'b0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      foreach (DIRECTED[r]) begin
         if (DIRECTED[r].kind == ROW_CSR) begin
            if (after_beat) drain_pipeline();
            write_reg(DIRECTED[r].code, DIRECTED[r].pan);
            after_beat = 1'b0;
         end else begin
            send_beat(DIRECTED[r].code, DIRECTED[r].pan, DIRECTED[r].tilt,
                      DIRECTED[r].literal, '{DIRECTED[r].exp_pan, DIRECTED[r].exp_tilt});
            after_beat = 1'b1;
         end
      end

      for (int phase = 0; phase < PHASES; phase++) begin
         drain_pipeline();
         choose_settings(phase);
         eager_phase = (phase % 4 == 3);
         for (int n = 0; n < PHASE_BEATS; n++) begin
            pick    = $urandom_range(0, 99);
            pan_in  = draw_value(pick >= 55 && pick < 65 || $urandom_range(0, 3) == 0);
            tilt_in = draw_value(pick >= 55 && pick < 65 || $urandom_range(0, 3) == 0);
            if (pick < 65) op = OP_TRACK;
            else if (pick < 73) op = OP_ABSOLUTE;
            else if (pick < 81) op = OP_OFFSET;
            else if (pick < 87) op = OP_HOME;
            else if (pick < 94) op = OP_CLEAR;
            else op = 3'($urandom_range(OP_UNUSED_FIRST, OP_UNUSED_LAST));
            send_beat(op, pan_in, tilt_in, 1'b0, '0);
         end
      end

      eager_phase = 1'b0;
      req_valid <= 1'b0;
      while (pending_angles.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (bad_beats == 0) begin
         $display("tb_pan_tilt_pd_tracker_core passed");
      end else begin
         $display("tb_pan_tilt_pd_tracker_core failed");
      end
      $finish;
   end

endmodule

@@ filelist.f @@
sv/ptpd_pkg.sv
sv/ptpd_axis_lane.sv
sv/ptpd_merge.sv
sv/pan_tilt_pd_tracker_core.sv
tb/sv/tb_pan_tilt_pd_tracker_core.sv
